### sv/assert_macros.svh
// assertion helpers shared by the rtl
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// same-cycle implication, checked outside reset
`define ASSERT_IMPL(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("assertion failed");

// next-cycle implication, checked outside reset
`define ASSERT_NEXT(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("assertion failed");

`endif

### sv/svnt_pkg.sv
package svnt_pkg;

   localparam int DEFAULT_ENTRIES = 256;
   localparam int DEFAULT_LEVELS  = 16;
   localparam int ID_W  = 29;
   localparam int ENC_W = 30;
   localparam int KEY_W = 64;
   localparam int REQ_W = 104;
   localparam int RSP_W = 40;

   // actions
   localparam logic [2:0] ACT_DECLARE = 3'd0;
   localparam logic [2:0] ACT_NUMBER  = 3'd1;
   localparam logic [2:0] ACT_TEST    = 3'd2;
   localparam logic [2:0] ACT_VARGID  = 3'd3;
   localparam logic [2:0] ACT_TEMPLID = 3'd4;
   localparam logic [2:0] ACT_INVAL   = 3'd5;
   localparam logic [2:0] ACT_ENTER   = 3'd6;
   localparam logic [2:0] ACT_LEAVE   = 3'd7;

   // operand kinds and operator classes
   localparam logic [1:0] KIND_VAR   = 2'd0;
   localparam logic [1:0] KIND_TEMP  = 2'd1;
   localparam logic [1:0] KIND_CONST = 2'd2;
   localparam logic [1:0] KIND_BAD   = 2'd3;
   localparam logic [1:0] CLS_REL    = 2'd0;
   localparam logic [1:0] CLS_ADD    = 2'd1;
   localparam logic [1:0] CLS_MUL    = 2'd2;
   localparam logic [1:0] CLS_BAD    = 2'd3;

   // result status codes
   localparam logic [2:0] ST_OK       = 3'd0;
   localparam logic [2:0] ST_NOTFOUND = 3'd1;
   localparam logic [2:0] ST_BADOP    = 3'd2;
   localparam logic [2:0] ST_DUP      = 3'd3;
   localparam logic [2:0] ST_FULL     = 3'd4;
   localparam logic [2:0] ST_SCOPE    = 3'd5;

   typedef enum logic [3:0] {
      S_IDLE, S_DECODE, S_DECL_SCAN, S_OPER_SCAN, S_KEY_SCAN, S_ID_SCAN,
      S_INV_SCAN, S_INV_POP, S_INV_LOAD, S_LEAVE_SCAN, S_RESULT
   } state_type;

   typedef enum logic [2:0] {
      MODE_VAR_CUR, MODE_VAR_NAME, MODE_VAR_OPS, MODE_KEY, MODE_GID,
      MODE_INV, MODE_LEAVE
   } mode_type;

   typedef enum logic [3:0] {
      RES_NONE, RES_DECL, RES_BADOP, RES_EXPR, RES_VARGID, RES_TEMPLID,
      RES_ENTER, RES_LEAVE
   } res_type;

   typedef struct packed {
      logic     load_req;
      logic     scan_start;
      mode_type mode;
      logic     enc_load;
      logic     inv_seed;
      logic     pop;
      logic     g_load_pop;
      res_type  res;
      logic     out_load;
   } cmd_type;

   typedef struct packed {
      logic [2:0] action;
      logic       bad_operand;
      logic       has_var;
      logic       oper_ok;
      logic       hit_a;
      logic       scope_zero;
      logic       depth_zero;
      logic       scan_done;
      logic       rsp_free;
   } stat_type;

   // operand encoding: variable and temporary shift up, constant sets bit 0
   function automatic logic [ENC_W-1:0] enc_operand(input logic [1:0] kind,
         input logic [ID_W-1:0] value, input logic [ID_W-1:0] gid);
      logic [ENC_W-1:0] r;
      begin
         r = '0;
         case (kind)
            KIND_VAR:   r = {gid, 1'b0};
            KIND_TEMP:  r = {value, 1'b0};
            KIND_CONST: r = {value, 1'b1};
            default:    r = '0;
         endcase
         return r;
      end
   endfunction

   // operator number in the key
   function automatic logic [3:0] op_number(input logic [1:0] cls, input logic [2:0] code);
      logic [3:0] r;
      begin
         case (cls)
            CLS_REL: r = {1'b0, code};
            CLS_ADD: r = {1'b0, code} + 4'd6;
            CLS_MUL: r = {1'b0, code} + 4'd8;
            default: r = '0;
         endcase
         return r;
      end
   endfunction

   function automatic logic op_commutes(input logic [1:0] cls, input logic [2:0] code);
      logic r;
      begin
         case (cls)
            CLS_REL:          r = code > 3'd3;
            CLS_ADD, CLS_MUL: r = code == 3'd0;
            default:          r = 1'b0;
         endcase
         return r;
      end
   endfunction

endpackage

### sv/scoped_value_number_table.sv
// Scoped value-number table. One request word in, exactly one response word
// out, one request at a time. Every lookup walks the whole table through one
// registered read port: the response word shows in the same cycle in which the
// next request can be taken. A number request with a variable operand adds a
// second pass over the table; invalidate of a known variable adds a pass, plus
// a stack pop, a reload and a further pass per removed dependent expression.
// Enter, leave at level zero and bad-operand requests skip the table walk. A
// stalled response holds back the next result, but a new request is accepted
// while the previous response still waits.
module scoped_value_number_table
   import svnt_pkg::*;
#(
   parameter int ENTRIES = DEFAULT_ENTRIES,
   parameter int LEVELS  = DEFAULT_LEVELS
) (
   input  logic             clock,
   input  logic             reset,
   input  logic             req_tvalid,
   output logic             req_tready,
   // action, left_kind, left_value, right_kind, right_value, op_class,
   // op_code, name_id
   input  logic [REQ_W-1:0] req_tdata,
   output logic             rsp_tvalid,
   input  logic             rsp_tready,
   // status, number, created
   output logic [RSP_W-1:0] rsp_tdata
);

   cmd_type  cmd;
   stat_type st;

   svnt_ctrl u_ctrl (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .st         (st),
      .cmd        (cmd)
   );

   svnt_dpath #(
      .ENTRIES (ENTRIES),
      .LEVELS  (LEVELS)
   ) u_dpath (
      .clock      (clock),
      .reset      (reset),
      .req_tdata  (req_tdata),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .cmd        (cmd),
      .st         (st)
   );

endmodule

### sv/svnt_ctrl.sv
module svnt_ctrl
   import svnt_pkg::*;
(
   input  logic     clock,
   input  logic     reset,
   input  logic     req_tvalid,
   output logic     req_tready,
   input  stat_type st,
   output cmd_type  cmd
);

   state_type state_ff, state_in;

   // state register
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= S_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

   // next state and commands
   always_comb begin
      state_in   = state_ff;
      cmd        = '0;
      cmd.mode   = MODE_VAR_CUR;
      cmd.res    = RES_NONE;
      req_tready = 1'b0;
      unique case (state_ff)
         S_IDLE: begin
            req_tready = 1'b1;
            if (req_tvalid) begin
               cmd.load_req = 1'b1;
               state_in     = S_DECODE;
            end
         end
         S_DECODE: begin
            unique case (st.action)
               ACT_DECLARE: begin
                  cmd.scan_start = 1'b1;
                  cmd.mode       = MODE_VAR_CUR;
                  state_in       = S_DECL_SCAN;
               end
               ACT_NUMBER, ACT_TEST: begin
                  if (st.bad_operand) begin
                     cmd.res  = RES_BADOP;
                     state_in = S_RESULT;
                  end else if (st.has_var) begin
                     cmd.scan_start = 1'b1;
                     cmd.mode       = MODE_VAR_OPS;
                     state_in       = S_OPER_SCAN;
                  end else begin
                     cmd.enc_load   = 1'b1;
                     cmd.scan_start = 1'b1;
                     cmd.mode       = MODE_KEY;
                     state_in       = S_KEY_SCAN;
                  end
               end
               ACT_VARGID, ACT_INVAL: begin
                  cmd.scan_start = 1'b1;
                  cmd.mode       = MODE_VAR_NAME;
                  state_in       = S_ID_SCAN;
               end
               ACT_TEMPLID: begin
                  cmd.scan_start = 1'b1;
                  cmd.mode       = MODE_GID;
                  state_in       = S_ID_SCAN;
               end
               ACT_ENTER: begin
                  cmd.res  = RES_ENTER;
                  state_in = S_RESULT;
               end
               ACT_LEAVE: begin
                  if (st.scope_zero) begin
                     cmd.res  = RES_LEAVE;
                     state_in = S_RESULT;
                  end else begin
                     cmd.scan_start = 1'b1;
                     cmd.mode       = MODE_LEAVE;
                     state_in       = S_LEAVE_SCAN;
                  end
               end
               default: state_in = S_IDLE;
            endcase
         end
         S_DECL_SCAN: begin
            cmd.mode = MODE_VAR_CUR;
            if (st.scan_done) begin
               cmd.res  = RES_DECL;
               state_in = S_RESULT;
            end
         end
         S_OPER_SCAN: begin
            cmd.mode = MODE_VAR_OPS;
            if (st.scan_done) begin
               if (!st.oper_ok) begin
                  cmd.res  = RES_BADOP;
                  state_in = S_RESULT;
               end else begin
                  cmd.enc_load   = 1'b1;
                  cmd.scan_start = 1'b1;
                  cmd.mode       = MODE_KEY;
                  state_in       = S_KEY_SCAN;
               end
            end
         end
         S_KEY_SCAN: begin
            cmd.mode = MODE_KEY;
            if (st.scan_done) begin
               cmd.res  = RES_EXPR;
               state_in = S_RESULT;
            end
         end
         S_ID_SCAN: begin
            cmd.mode = (st.action == ACT_TEMPLID) ? MODE_GID : MODE_VAR_NAME;
            if (st.scan_done) begin
               if (st.action == ACT_TEMPLID) begin
                  cmd.res  = RES_TEMPLID;
                  state_in = S_RESULT;
               end else begin
                  cmd.res = RES_VARGID;
                  if (st.action == ACT_INVAL && st.hit_a) begin
                     cmd.inv_seed   = 1'b1;
                     cmd.scan_start = 1'b1;
                     cmd.mode       = MODE_INV;
                     state_in       = S_INV_SCAN;
                  end else begin
                     state_in = S_RESULT;
                  end
               end
            end
         end
         S_INV_SCAN: begin
            cmd.mode = MODE_INV;
            if (st.scan_done) begin
               state_in = S_INV_POP;
            end
         end
         S_INV_POP: begin
            cmd.mode = MODE_INV;
            if (st.depth_zero) begin
               state_in = S_RESULT;
            end else begin
               cmd.pop  = 1'b1;
               state_in = S_INV_LOAD;
            end
         end
         S_INV_LOAD: begin
            cmd.mode       = MODE_INV;
            cmd.g_load_pop = 1'b1;
            cmd.scan_start = 1'b1;
            state_in       = S_INV_SCAN;
         end
         S_LEAVE_SCAN: begin
            cmd.mode = MODE_LEAVE;
            if (st.scan_done) begin
               cmd.res  = RES_LEAVE;
               state_in = S_RESULT;
            end
         end
         S_RESULT: begin
            if (st.rsp_free) begin
               cmd.out_load = 1'b1;
               state_in     = S_IDLE;
            end
         end
         default: state_in = S_IDLE;
      endcase
   end

endmodule

### sv/svnt_dpath.sv
module svnt_dpath
   import svnt_pkg::*;
#(
   parameter int ENTRIES = DEFAULT_ENTRIES,
   parameter int LEVELS  = DEFAULT_LEVELS
) (
   input  logic             clock,
   input  logic             reset,
   input  logic [REQ_W-1:0] req_tdata,
   output logic             rsp_tvalid,
   input  logic             rsp_tready,
   output logic [RSP_W-1:0] rsp_tdata,
   input  cmd_type          cmd,
   output stat_type         st
);

`include "assert_macros.svh"

   localparam int IDX_W = $clog2(ENTRIES);
   localparam int DEP_W = $clog2(ENTRIES + 1);
   localparam int LVL_W = (LEVELS > 1) ? $clog2(LEVELS) : 1;

   // table memory and pending stack
   logic             mem_expr [ENTRIES];
   logic [KEY_W-1:0] mem_key  [ENTRIES];
   logic [ID_W-1:0]  mem_glob [ENTRIES];
   logic [ID_W-1:0]  mem_loc  [ENTRIES];
   logic [LVL_W-1:0] mem_lvl  [ENTRIES];
   logic [ID_W-1:0]  pend_mem [ENTRIES];
   logic [ENTRIES-1:0] used_ff;

   // latched request word
   logic [2:0]      act_ff;
   logic [1:0]      lk_ff, rk_ff, cls_ff;
   logic [ID_W-1:0] lv_ff, rv_ff, name_ff;
   logic [2:0]      code_ff;

   logic [LVL_W-1:0] scope_ff;
   logic [ID_W-1:0]  next_glob_ff, next_loc_ff;
   logic [ENC_W-1:0] enc_l_ff, enc_r_ff;
   logic [ID_W-1:0]  g_ff, pend_rd_ff;
   logic [DEP_W-1:0] depth_ff;

   // scan pipeline
   logic             busy_ff, ev_ff, done_ff;
   logic [IDX_W-1:0] idx_ff, ev_idx_ff;
   mode_type         mode_ff;
   logic             rd_expr_ff;
   logic [KEY_W-1:0] rd_key_ff;
   logic [ID_W-1:0]  rd_glob_ff, rd_loc_ff;
   logic [LVL_W-1:0] rd_lvl_ff;

   // best matches and first free slot
   logic             a_v_ff, b_v_ff, free_v_ff;
   logic [LVL_W-1:0] a_lvl_ff, b_lvl_ff;
   logic [ID_W-1:0]  a_glob_ff, a_loc_ff, b_glob_ff;
   logic [IDX_W-1:0] free_idx_ff;

   // result and output registers
   logic [2:0]      res_status_ff, res_status_in;
   logic [ID_W-1:0] res_number_ff, res_number_in;
   logic            res_created_ff, res_created_in;
   logic            out_v_ff;
   logic [RSP_W-1:0] out_data_ff;

   logic             used_ev, vis, hit_a, hit_b, kill, inv_match, comm, ins_var, ins_expr;
   logic             push;
   logic [KEY_W-1:0] key_fwd, key_swp;
   logic [3:0]       opn;
   logic             expr_hit;
   logic [ID_W-1:0]  expr_glob;

   // request capture
   always_ff @(posedge clock) begin
      if (cmd.load_req) begin
         act_ff  <= req_tdata[2:0];
         lk_ff   <= req_tdata[4:3];
         lv_ff   <= req_tdata[33:5];
         rk_ff   <= req_tdata[35:34];
         rv_ff   <= req_tdata[64:36];
         cls_ff  <= req_tdata[66:65];
         code_ff <= req_tdata[69:67];
         name_ff <= req_tdata[98:70];
      end
   end

   // keys from the encoded operands
   always_comb begin
      opn     = op_number(cls_ff, code_ff);
      comm    = op_commutes(cls_ff, code_ff);
      key_fwd = {enc_l_ff, enc_r_ff, opn};
      key_swp = {enc_r_ff, enc_l_ff, opn};
   end

   // scan address and read
   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         ev_ff   <= 1'b0;
         done_ff <= 1'b0;
      end else begin
         ev_ff   <= busy_ff;
         done_ff <= ev_ff && (ev_idx_ff == IDX_W'(ENTRIES - 1));
         if (cmd.scan_start) begin
            busy_ff <= 1'b1;
         end else if (busy_ff && idx_ff == IDX_W'(ENTRIES - 1)) begin
            busy_ff <= 1'b0;
         end
      end
   end

   always_ff @(posedge clock) begin
      ev_idx_ff <= idx_ff;
      if (cmd.scan_start) begin
         idx_ff  <= '0;
         mode_ff <= cmd.mode;
      end else if (busy_ff) begin
         idx_ff <= idx_ff + 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      rd_expr_ff <= mem_expr[idx_ff];
      rd_key_ff  <= mem_key[idx_ff];
      rd_glob_ff <= mem_glob[idx_ff];
      rd_loc_ff  <= mem_loc[idx_ff];
      rd_lvl_ff  <= mem_lvl[idx_ff];
   end

   // per-entry match
   always_comb begin
      used_ev   = used_ff[ev_idx_ff];
      vis       = used_ev && rd_lvl_ff <= scope_ff &&
                  (mode_ff != MODE_VAR_CUR || rd_lvl_ff == scope_ff);
      inv_match = (rd_key_ff[63:35] == g_ff && !rd_key_ff[34]) ||
                  (rd_key_ff[33:5] == g_ff && !rd_key_ff[4]);
      hit_a = 1'b0;
      hit_b = 1'b0;
      kill  = 1'b0;
      unique case (mode_ff)
         MODE_VAR_CUR, MODE_VAR_NAME: hit_a = vis && !rd_expr_ff && rd_loc_ff == name_ff;
         MODE_VAR_OPS: begin
            hit_a = vis && !rd_expr_ff && rd_loc_ff == lv_ff;
            hit_b = vis && !rd_expr_ff && rd_loc_ff == rv_ff;
         end
         MODE_KEY: begin
            hit_a = vis && comm && rd_expr_ff && rd_key_ff == key_swp;
            hit_b = vis && rd_expr_ff && rd_key_ff == key_fwd;
         end
         MODE_GID:   hit_a = vis && rd_expr_ff && rd_glob_ff == name_ff;
         MODE_INV:   kill  = used_ev && rd_expr_ff && rd_lvl_ff <= scope_ff && inv_match;
         MODE_LEAVE: kill  = used_ev && rd_lvl_ff >= scope_ff;
         default: ;
      endcase
      push = ev_ff && kill && mode_ff == MODE_INV && depth_ff < DEP_W'(ENTRIES);
   end

   // best-match tracking, innermost level wins, lowest index on ties
   always_ff @(posedge clock) begin
      if (cmd.scan_start) begin
         a_v_ff    <= 1'b0;
         b_v_ff    <= 1'b0;
         free_v_ff <= 1'b0;
      end else if (ev_ff) begin
         if (hit_a && (!a_v_ff || rd_lvl_ff > a_lvl_ff)) begin
            a_v_ff    <= 1'b1;
            a_lvl_ff  <= rd_lvl_ff;
            a_glob_ff <= rd_glob_ff;
            a_loc_ff  <= rd_loc_ff;
         end
         if (hit_b && (!b_v_ff || rd_lvl_ff > b_lvl_ff)) begin
            b_v_ff    <= 1'b1;
            b_lvl_ff  <= rd_lvl_ff;
            b_glob_ff <= rd_glob_ff;
         end
         if (!used_ev && !free_v_ff) begin
            free_v_ff   <= 1'b1;
            free_idx_ff <= ev_idx_ff;
         end
      end
   end

   // result decisions
   always_comb begin
      expr_hit  = (comm && a_v_ff) || b_v_ff;
      expr_glob = (comm && a_v_ff) ? a_glob_ff : b_glob_ff;
      ins_var   = cmd.res == RES_DECL && !a_v_ff && free_v_ff;
      ins_expr  = cmd.res == RES_EXPR && !expr_hit && act_ff == ACT_NUMBER && free_v_ff;
   end

   // table write on insert
   always_ff @(posedge clock) begin
      if (ins_var || ins_expr) begin
         mem_expr[free_idx_ff] <= ins_expr;
         mem_key[free_idx_ff]  <= ins_expr ? key_fwd : '0;
         mem_glob[free_idx_ff] <= next_glob_ff;
         mem_loc[free_idx_ff]  <= ins_expr ? next_loc_ff : name_ff;
         mem_lvl[free_idx_ff]  <= scope_ff;
      end
   end

   // valid bits
   always_ff @(posedge clock) begin
      if (reset) begin
         used_ff <= '0;
      end else begin
         if (ev_ff && kill) begin
            used_ff[ev_idx_ff] <= 1'b0;
         end
         if (ins_var || ins_expr) begin
            used_ff[free_idx_ff] <= 1'b1;
         end
      end
   end

   // pending stack for transitive invalidation
   always_ff @(posedge clock) begin
      if (push) begin
         pend_mem[depth_ff[IDX_W-1:0]] <= rd_glob_ff;
      end
      if (cmd.pop) begin
         pend_rd_ff <= pend_mem[IDX_W'(depth_ff - 1'b1)];
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         depth_ff <= '0;
      end else if (push) begin
         depth_ff <= depth_ff + 1'b1;
      end else if (cmd.pop) begin
         depth_ff <= depth_ff - 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.inv_seed) begin
         g_ff <= a_glob_ff;
      end else if (cmd.g_load_pop) begin
         g_ff <= pend_rd_ff;
      end
      if (cmd.enc_load) begin
         enc_l_ff <= enc_operand(lk_ff, lv_ff, a_glob_ff);
         enc_r_ff <= enc_operand(rk_ff, rv_ff, b_glob_ff);
      end
   end

   // counters, scope and result word
   always_ff @(posedge clock) begin
      if (reset) begin
         scope_ff     <= '0;
         next_glob_ff <= '0;
         next_loc_ff  <= '0;
      end else begin
         if (ins_var || ins_expr) begin
            next_glob_ff <= next_glob_ff + 1'b1;
         end
         if (ins_expr) begin
            next_loc_ff <= next_loc_ff + 1'b1;
         end
         if (cmd.res == RES_ENTER && scope_ff != LVL_W'(LEVELS - 1)) begin
            scope_ff <= scope_ff + 1'b1;
         end
         if (cmd.res == RES_LEAVE && scope_ff != '0) begin
            scope_ff <= scope_ff - 1'b1;
         end
      end
   end

   always_comb begin
      res_status_in  = ST_OK;
      res_number_in  = '0;
      res_created_in = 1'b0;
      case (cmd.res)
         RES_DECL: begin
            if (a_v_ff) begin
               res_status_in = ST_DUP;
               res_number_in = a_glob_ff;
            end else if (!free_v_ff) begin
               res_status_in = ST_FULL;
            end else begin
               res_number_in = next_glob_ff;
            end
         end
         RES_BADOP: res_status_in = ST_BADOP;
         RES_EXPR: begin
            if (expr_hit) begin
               res_number_in = expr_glob;
            end else if (act_ff == ACT_TEST) begin
               res_status_in = ST_NOTFOUND;
            end else if (!free_v_ff) begin
               res_status_in = ST_FULL;
            end else begin
               res_number_in  = next_glob_ff;
               res_created_in = 1'b1;
            end
         end
         RES_VARGID: begin
            if (a_v_ff) begin
               res_number_in = a_glob_ff;
            end else begin
               res_status_in = ST_NOTFOUND;
            end
         end
         RES_TEMPLID: begin
            if (a_v_ff) begin
               res_number_in = a_loc_ff;
            end else begin
               res_status_in = ST_NOTFOUND;
            end
         end
         RES_ENTER: begin
            if (scope_ff == LVL_W'(LEVELS - 1)) begin
               res_status_in = ST_SCOPE;
            end
         end
         RES_LEAVE: begin
            if (scope_ff == '0) begin
               res_status_in = ST_SCOPE;
            end
         end
         default: ;
      endcase
   end

   always_ff @(posedge clock) begin
      if (cmd.res != RES_NONE) begin
         res_status_ff  <= res_status_in;
         res_number_ff  <= res_number_in;
         res_created_ff <= res_created_in;
      end
   end

   // output register
   always_ff @(posedge clock) begin
      if (reset) begin
         out_v_ff <= 1'b0;
      end else if (cmd.out_load) begin
         out_v_ff <= 1'b1;
      end else if (rsp_tready) begin
         out_v_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.out_load) begin
         out_data_ff <= {7'd0, res_created_ff, res_number_ff, res_status_ff};
      end
   end

   assign rsp_tvalid = out_v_ff;
   assign rsp_tdata  = out_data_ff;

   // status back to the controller
   always_comb begin
      st.action      = act_ff;
      st.bad_operand = cls_ff == CLS_BAD || lk_ff == KIND_BAD || rk_ff == KIND_BAD;
      st.has_var     = lk_ff == KIND_VAR || rk_ff == KIND_VAR;
      st.oper_ok     = (lk_ff != KIND_VAR || a_v_ff) && (rk_ff != KIND_VAR || b_v_ff);
      st.hit_a       = a_v_ff;
      st.scope_zero  = scope_ff == '0;
      st.depth_zero  = depth_ff == '0;
      st.scan_done   = done_ff;
      st.rsp_free    = !out_v_ff || rsp_tready;
   end

   `ASSERT_IMPL(a_depth_bound, clock, reset, 1'b1, depth_ff <= DEP_W'(ENTRIES))
   `ASSERT_IMPL(a_no_insert_in_scan, clock, reset, ins_var || ins_expr, !busy_ff && !ev_ff)
   `ASSERT_NEXT(a_scan_runs, clock, reset, cmd.scan_start, busy_ff && !done_ff)

endmodule
